// ===== src/ray_triangle_intersect_unit_defines.svh =====
// Assertion macros shared by the ray/triangle intersection unit.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef RAY_TRIANGLE_INTERSECT_UNIT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rti_pkg.sv =====
// Shared types and constants of the ray/triangle intersection unit.
// Depends on nothing.
package rti_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_EPSILON  = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MISS_NONE     = 3'd0,
        MISS_PARALLEL = 3'd1,
        MISS_U_OUT    = 3'd2,
        MISS_V_OUT    = 3'd3,
        MISS_T_SMALL  = 3'd4
    } miss_reason_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_stat_t;

endpackage

// ===== src/rti_if.sv =====
// Channel interfaces of the ray/triangle intersection unit: triangles in, results out.
// Depends on nothing.
interface rti_tri_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_a_x;
    logic signed [COORD_WIDTH-1:0] vertex_a_y;
    logic signed [COORD_WIDTH-1:0] vertex_a_z;
    logic signed [COORD_WIDTH-1:0] vertex_b_x;
    logic signed [COORD_WIDTH-1:0] vertex_b_y;
    logic signed [COORD_WIDTH-1:0] vertex_b_z;
    logic signed [COORD_WIDTH-1:0] vertex_c_x;
    logic signed [COORD_WIDTH-1:0] vertex_c_y;
    logic signed [COORD_WIDTH-1:0] vertex_c_z;

    modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
                    vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                    input ready);
    modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
                  vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                  output ready);
endinterface

interface rti_res_if #(parameter int COORD_WIDTH = 32, parameter int FRAC_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [2:0]                    miss_reason;
    logic [COORD_WIDTH-2:0]        distance;
    logic [FRAC_BITS:0]            bary_u;
    logic [FRAC_BITS:0]            bary_v;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (output valid, hit, miss_reason, distance, bary_u, bary_v,
                    point_x, point_y, point_z, input ready);
    modport sink (input valid, hit, miss_reason, distance, bary_u, bary_v,
                  point_x, point_y, point_z, output ready);
endinterface

// ===== src/rti_mul.sv =====
// Two-stage signed multiplier: the wide operand is split in two halves.
// Depends on nothing.
module rti_mul #(
    parameter int AW = 33,
    parameter int BW = 66
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0] p
);
    localparam int LW = BW / 2;
    localparam int HW = BW - LW;

    logic signed [AW+LW:0]    pl_next, pl_reg;
    logic signed [AW+HW-1:0]  ph_next, ph_reg;
    logic signed [AW+BW-1:0]  p_reg;

    // Low half is taken unsigned, high half carries the sign.
    assign pl_next = a * $signed({1'b0, b[LW-1:0]});
    assign ph_next = a * $signed(b[BW-1:LW]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
            p_reg  <= $signed({ph_reg, {LW{1'b0}}}) + (AW+BW)'(pl_reg);
        end
    end

    assign p = p_reg;
endmodule

// ===== src/rti_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero
// and saturating to the signed coordinate range. Depends on nothing.
module rti_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int NW          = 102
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [NW-1:0]          num,
    input  logic signed [NW-1:0]          den,
    output logic signed [COORD_WIDTH-1:0] quo
);
    localparam int C  = COORD_WIDTH;
    localparam int Q  = C + 1;
    localparam int AW = NW + FRAC_BITS;
    localparam int WW = NW + Q + FRAC_BITS;
    localparam logic signed [C+1:0] Q_MAX = (C+2)'({1'b0, {(C-1){1'b1}}});
    localparam logic signed [C+1:0] Q_MIN = ~Q_MAX;

    logic [AW-1:0] rem_reg [Q+1];
    logic [NW-1:0] d_reg   [Q+1];
    logic [Q-1:0]  q_reg   [Q+1];
    logic          neg_reg [Q+1];
    logic          ovf_reg [Q+1];

    logic [NW-1:0]         n_abs, d_abs;
    logic [AW-1:0]         a_sh;
    logic signed [C+1:0]   q_signed;
    logic signed [C-1:0]   quo_next, quo_reg;

    assign n_abs = num[NW-1] ? NW'(-num) : NW'(num);
    assign d_abs = den[NW-1] ? NW'(-den) : NW'(den);
    assign a_sh  = {n_abs, {FRAC_BITS{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= a_sh;
            d_reg[0]   <= d_abs;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NW-1] ^ den[NW-1];
            ovf_reg[0] <= WW'(a_sh) >= (WW'(d_abs) << Q);
        end
    end

    for (genvar k = 1; k <= Q; k++)
    begin : g_bit
        logic [WW-1:0] d_sh;
        logic          ge;

        assign d_sh = WW'(d_reg[k-1]) << (Q - k);
        assign ge   = WW'(rem_reg[k-1]) >= d_sh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? AW'(WW'(rem_reg[k-1]) - d_sh) : rem_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (ge ? (Q'(1) << (Q - k)) : Q'(0));
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    always_comb
    begin
        q_signed = neg_reg[Q] ? -(C+2)'(q_reg[Q]) : (C+2)'(q_reg[Q]);
        if (ovf_reg[Q])
            quo_next = neg_reg[Q] ? Q_MIN[C-1:0] : Q_MAX[C-1:0];
        else if (q_signed > Q_MAX)
            quo_next = Q_MAX[C-1:0];
        else if (q_signed < Q_MIN)
            quo_next = Q_MIN[C-1:0];
        else
            quo_next = q_signed[C-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= quo_next;
    end

    assign quo = quo_reg;
endmodule

// ===== src/rti_front.sv =====
// Front end: accepts triangles, forms the edge vectors and queues them.
// Depends on rti_pkg.
module rti_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0][COORD_WIDTH-1:0]      va,
    input  logic [2:0][COORD_WIDTH-1:0]      vb,
    input  logic [2:0][COORD_WIDTH-1:0]      vc,
    input  logic [2:0][COORD_WIDTH-1:0]      org,
    input  logic                             pop,
    output rti_pkg::queue_stat_t             q_stat,
    output logic [2:0][COORD_WIDTH:0]        e1,
    output logic [2:0][COORD_WIDTH:0]        e2,
    output logic [2:0][COORD_WIDTH:0]        tv
);
    import rti_pkg::*;

    localparam int E  = COORD_WIDTH + 1;
    localparam int EW = 9 * E;

    logic                  f_vld_reg, f_vld_next;
    logic [2:0][E-1:0]     f_e1_reg, f_e2_reg, f_tv_reg;
    logic [2:0][E-1:0]     e1_next, e2_next, tv_next;
    logic [EW-1:0]         mem_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] cnt_reg;
    logic                  load, push, q_full, q_pop;

    assign q_full   = cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign in_ready = !f_vld_reg || !q_full;
    assign load     = in_valid && in_ready;
    assign push     = f_vld_reg && !q_full;
    assign q_pop    = pop && (cnt_reg != '0);

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            e1_next[j] = E'($signed(vb[j])) - E'($signed(va[j]));
            e2_next[j] = E'($signed(vc[j])) - E'($signed(va[j]));
            tv_next[j] = E'($signed(org[j])) - E'($signed(va[j]));
        end
        if (load)
            f_vld_next = 1'b1;
        else if (push)
            f_vld_next = 1'b0;
        else
            f_vld_next = f_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg  <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            f_vld_reg <= f_vld_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !q_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (q_pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            f_e1_reg <= e1_next;
            f_e2_reg <= e2_next;
            f_tv_reg <= tv_next;
        end
        if (push)
            mem_reg[wr_ptr_reg] <= {f_tv_reg, f_e2_reg, f_e1_reg};
    end

    assign {tv, e2, e1}     = mem_reg[rd_ptr_reg];
    assign q_stat.not_empty = cnt_reg != '0;
    assign q_stat.full      = q_full;
endmodule

// ===== src/rti_back.sv =====
// Back end: cross and dot products, three dividers, hit decision and hit point.
// Depends on rti_pkg, rti_mul and rti_div.
module rti_back #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              take,
    input  logic [2:0][COORD_WIDTH:0]         e1,
    input  logic [2:0][COORD_WIDTH:0]         e2,
    input  logic [2:0][COORD_WIDTH:0]         tv,
    input  logic [2:0][COORD_WIDTH-1:0]       org,
    input  logic [2:0][COORD_WIDTH-1:0]       dir,
    input  logic [COORD_WIDTH-2:0]            eps,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic [2:0]                        miss_reason,
    output logic [COORD_WIDTH-2:0]            distance,
    output logic [FRAC_BITS:0]                bary_u,
    output logic [FRAC_BITS:0]                bary_v,
    output logic [2:0][COORD_WIDTH-1:0]       point
);
    import rti_pkg::*;

    localparam int C    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int E    = C + 1;
    localparam int PW   = C + E + 1;
    localparam int QW   = 2 * E + 1;
    localparam int NW   = 3 * C + 6;
    localparam int Q    = C + 1;
    localparam int DLAT = Q + 2;
    localparam int NS   = DLAT + 8;
    localparam logic signed [C:0]   ONE_Q = (C+1)'(1) << F;
    localparam logic signed [2*C:0] PT_HI = (2*C+1)'({1'b0, {(C-1){1'b1}}});
    localparam logic signed [2*C:0] PT_LO = ~PT_HI;

    logic              en;
    logic [NS:1]       vld_reg;

    // Stage 1-2 products for the two cross products.
    logic signed [C+E-1:0] pva [3], pvb [3];
    logic signed [2*E-1:0] qva [3], qvb [3];
    logic [2:0][E-1:0]     e1_1_reg, e2_1_reg, tv_1_reg;
    logic [2:0][E-1:0]     e1_2_reg, e2_2_reg, tv_2_reg;
    logic [2:0][E-1:0]     e1_3_reg, e2_3_reg, tv_3_reg;
    logic signed [PW-1:0]  pv_reg [3];
    logic signed [QW-1:0]  qv_reg [3];

    // Stage 4-5 products for the dot products.
    logic signed [E+PW-1:0] pd [3], pu [3];
    logic signed [C+QW-1:0] pn [3];
    logic signed [E+QW-1:0] pt [3];
    logic signed [NW-1:0]   det_reg, nu_reg, nv_reg, nt_reg;

    logic [NW-1:0]          det_abs;
    logic                   par_reg [DLAT];
    logic signed [C-1:0]    u_q, v_q, t_q;

    logic signed [C:0]      uv_sum;
    miss_reason_t           reason_next, reason_reg;
    logic signed [C-1:0]    u_r_reg, v_r_reg, t_r_reg;
    logic signed [2*C-1:0]  prod_reg [3];
    logic signed [2*C:0]    pt_sum [3];
    logic signed [2*C:0]    pt_sh [3];

    logic                   hit_reg;
    miss_reason_t           out_reason_reg;
    logic [C-2:0]           dist_reg;
    logic [F:0]             bu_reg, bv_reg;
    logic [2:0][C-1:0]      point_reg;

    // The whole back end advances together; it holds while a result waits.
    assign en   = !vld_reg[NS] || out_ready;
    assign take = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-1:1], in_valid};
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_cross
        rti_mul #(.AW(C), .BW(E)) u_pva (.clk(clk), .en(en),
            .a(dir[(j+1)%3]), .b(e2[(j+2)%3]), .p(pva[j]));
        rti_mul #(.AW(C), .BW(E)) u_pvb (.clk(clk), .en(en),
            .a(dir[(j+2)%3]), .b(e2[(j+1)%3]), .p(pvb[j]));
        rti_mul #(.AW(E), .BW(E)) u_qva (.clk(clk), .en(en),
            .a(tv[(j+1)%3]), .b(e1[(j+2)%3]), .p(qva[j]));
        rti_mul #(.AW(E), .BW(E)) u_qvb (.clk(clk), .en(en),
            .a(tv[(j+2)%3]), .b(e1[(j+1)%3]), .p(qvb[j]));

        rti_mul #(.AW(E), .BW(PW)) u_det (.clk(clk), .en(en),
            .a(e1_3_reg[j]), .b(pv_reg[j]), .p(pd[j]));
        rti_mul #(.AW(E), .BW(PW)) u_nu (.clk(clk), .en(en),
            .a(tv_3_reg[j]), .b(pv_reg[j]), .p(pu[j]));
        rti_mul #(.AW(C), .BW(QW)) u_nv (.clk(clk), .en(en),
            .a(dir[j]), .b(qv_reg[j]), .p(pn[j]));
        rti_mul #(.AW(E), .BW(QW)) u_nt (.clk(clk), .en(en),
            .a(e2_3_reg[j]), .b(qv_reg[j]), .p(pt[j]));
    end

    assign det_abs = det_reg[NW-1] ? NW'(-det_reg) : NW'(det_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_1_reg <= e1;
            e2_1_reg <= e2;
            tv_1_reg <= tv;
            e1_2_reg <= e1_1_reg;
            e2_2_reg <= e2_1_reg;
            tv_2_reg <= tv_1_reg;
            e1_3_reg <= e1_2_reg;
            e2_3_reg <= e2_2_reg;
            tv_3_reg <= tv_2_reg;
            for (int j = 0; j < 3; j++)
            begin
                pv_reg[j] <= PW'(pva[j]) - PW'(pvb[j]);
                qv_reg[j] <= QW'(qva[j]) - QW'(qvb[j]);
            end
            det_reg <= NW'(pd[0]) + NW'(pd[1]) + NW'(pd[2]);
            nu_reg  <= NW'(pu[0]) + NW'(pu[1]) + NW'(pu[2]);
            nv_reg  <= NW'(pn[0]) + NW'(pn[1]) + NW'(pn[2]);
            nt_reg  <= NW'(pt[0]) + NW'(pt[1]) + NW'(pt[2]);
            // A zero determinant is parallel even with a zero tolerance.
            par_reg[0] <= (det_reg == '0) || (det_abs < (NW'(eps) << (2 * F)));
            for (int k = 1; k < DLAT; k++)
                par_reg[k] <= par_reg[k-1];
        end
    end

    rti_div #(.COORD_WIDTH(C), .FRAC_BITS(F), .NW(NW)) u_div_u (.clk(clk), .en(en),
        .num(nu_reg), .den(det_reg), .quo(u_q));
    rti_div #(.COORD_WIDTH(C), .FRAC_BITS(F), .NW(NW)) u_div_v (.clk(clk), .en(en),
        .num(nv_reg), .den(det_reg), .quo(v_q));
    rti_div #(.COORD_WIDTH(C), .FRAC_BITS(F), .NW(NW)) u_div_t (.clk(clk), .en(en),
        .num(nt_reg), .den(det_reg), .quo(t_q));

    assign uv_sum = (C+1)'(u_q) + (C+1)'(v_q);

    always_comb
    begin
        if (par_reg[DLAT-1])
            reason_next = MISS_PARALLEL;
        else if (u_q[C-1] || ((C+1)'(u_q) > ONE_Q))
            reason_next = MISS_U_OUT;
        else if (v_q[C-1] || (uv_sum > ONE_Q))
            reason_next = MISS_V_OUT;
        else if (t_q <= $signed({1'b0, eps}))
            reason_next = MISS_T_SMALL;
        else
            reason_next = MISS_NONE;
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            pt_sum[j] = (2*C+1)'($signed({org[j], {F{1'b0}}})) + (2*C+1)'(prod_reg[j]);
            pt_sh[j]  = pt_sum[j] >>> F;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            reason_reg <= reason_next;
            u_r_reg    <= u_q;
            v_r_reg    <= v_q;
            t_r_reg    <= t_q;
            for (int j = 0; j < 3; j++)
                prod_reg[j] <= $signed(dir[j]) * t_q;

            out_reason_reg <= reason_reg;
            if (reason_reg == MISS_NONE)
            begin
                hit_reg  <= 1'b1;
                dist_reg <= t_r_reg[C-2:0];
                bu_reg   <= u_r_reg[F:0];
                bv_reg   <= v_r_reg[F:0];
                for (int j = 0; j < 3; j++)
                begin
                    if (pt_sh[j] > PT_HI)
                        point_reg[j] <= PT_HI[C-1:0];
                    else if (pt_sh[j] < PT_LO)
                        point_reg[j] <= PT_LO[C-1:0];
                    else
                        point_reg[j] <= pt_sh[j][C-1:0];
                end
            end
            else
            begin
                hit_reg   <= 1'b0;
                dist_reg  <= '0;
                bu_reg    <= '0;
                bv_reg    <= '0;
                point_reg <= '0;
            end
        end
    end

    assign out_valid   = vld_reg[NS];
    assign hit         = hit_reg;
    assign miss_reason = out_reason_reg;
    assign distance    = dist_reg;
    assign bary_u      = bu_reg;
    assign bary_v      = bv_reg;
    assign point       = point_reg;
endmodule

// ===== src/ray_triangle_intersect_unit.sv =====
// Ray/triangle intersection unit (Moller-Trumbore) in signed fixed point.
// Depends on rti_pkg, rti_if, rti_front, rti_back and the assertion macro header.
//
// Usage: the ray origin, ray direction and epsilon are written through the plain
// write port (cfg_we, cfg_index, cfg_wdata) while the unit is idle. Triangles
// arrive on the triangle channel, one transaction per triangle; every triangle
// yields exactly one result transaction on the result channel, in order.
// A result carries the hit flag and a miss reason; on a hit it also carries the
// ray parameter t, the barycentric u and v and the hit point, and on a miss all
// of those are zero.
// Throughput: one triangle per clock cycle, sustained while result.ready stays high.
// An accepted triangle passes the front's input stage and queue, then the
// two-stage multipliers of the cross and dot products and the three pipelined
// dividers, which resolve one quotient bit per stage, before its result turns valid.
// Reset clears the pipeline and the queue; origin and direction reset to zero
// and epsilon to one.
// When the receiver stalls, the back pipeline holds its contents; the front
// keeps accepting until its four-entry queue and input stage are full, and only
// then drops triangle.ready.
`include "ray_triangle_intersect_unit_defines.svh"

module ray_triangle_intersect_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rti_tri_if.sink                          triangle,
    rti_res_if.source                        result,
    input  logic                             cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [COORD_WIDTH-1:0]           cfg_wdata
);
    import rti_pkg::*;

    localparam int C = COORD_WIDTH;
    localparam logic [FRAC_BITS+1:0] UV_ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

    // Configuration registers: the ray and the tolerance.
    logic [2:0][C-1:0] org_reg;
    logic [2:0][C-1:0] dir_reg;
    logic [C-2:0]      eps_reg;

    logic [2:0][C-1:0] va, vb, vc;
    logic [2:0][C:0]   e1, e2, tv;
    queue_stat_t       q_stat;
    logic              back_take;
    logic              q_pop;
    logic [2:0][C-1:0] point;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg <= '0;
            dir_reg <= '0;
            eps_reg <= (C-1)'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X: org_reg[0] <= cfg_wdata;
                REG_ORIGIN_Y: org_reg[1] <= cfg_wdata;
                REG_ORIGIN_Z: org_reg[2] <= cfg_wdata;
                REG_DIR_X:    dir_reg[0] <= cfg_wdata;
                REG_DIR_Y:    dir_reg[1] <= cfg_wdata;
                REG_DIR_Z:    dir_reg[2] <= cfg_wdata;
                REG_EPSILON:  eps_reg    <= cfg_wdata[C-2:0];
                default:      ;
            endcase
        end
    end

    assign va = {triangle.vertex_a_z, triangle.vertex_a_y, triangle.vertex_a_x};
    assign vb = {triangle.vertex_b_z, triangle.vertex_b_y, triangle.vertex_b_x};
    assign vc = {triangle.vertex_c_z, triangle.vertex_c_y, triangle.vertex_c_x};

    // The front forms the edge vectors and buffers them, so the input side keeps
    // moving while the back end is held by a stalled receiver.
    rti_front #(.COORD_WIDTH(C)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (triangle.valid),
        .in_ready (triangle.ready),
        .va       (va),
        .vb       (vb),
        .vc       (vc),
        .org      (org_reg),
        .pop      (q_pop),
        .q_stat   (q_stat),
        .e1       (e1),
        .e2       (e2),
        .tv       (tv)
    );

    assign q_pop = back_take && q_stat.not_empty;

    rti_back #(.COORD_WIDTH(C), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_stat.not_empty),
        .take        (back_take),
        .e1          (e1),
        .e2          (e2),
        .tv          (tv),
        .org         (org_reg),
        .dir         (dir_reg),
        .eps         (eps_reg),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .hit         (result.hit),
        .miss_reason (result.miss_reason),
        .distance    (result.distance),
        .bary_u      (result.bary_u),
        .bary_v      (result.bary_v),
        .point       (point)
    );

    assign result.point_x = point[0];
    assign result.point_y = point[1];
    assign result.point_z = point[2];

    // A miss carries no distance, barycentric coordinates or point; only point_x is checked.
    `RTI_ASSERT_NOW(a_miss_zero, result.valid && !result.hit, result.distance == '0 && result.bary_u == '0 && result.bary_v == '0 && result.point_x == '0, "miss result with nonzero payload")
    // A hit lies strictly beyond epsilon along the ray.
    `RTI_ASSERT_NOW(a_hit_dist, result.valid && result.hit, result.distance > eps_reg, "hit distance not above epsilon")
    // Barycentric coordinates of a hit stay inside the triangle.
    `RTI_ASSERT_NOW(a_hit_bary, result.valid && result.hit, ({1'b0, result.bary_u} + {1'b0, result.bary_v}) <= UV_ONE, "hit with u + v above one")
    // A full queue that the back end does not drain still holds entries next cycle.
    `RTI_ASSERT_NEXT(a_queue_hold, q_stat.full && !back_take, q_stat.not_empty, "queue lost entries while stalled")
endmodule
